// ===== rtl/core/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// tun_pkg
// Types and constants for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int CRD_W   = 16;          // Q8.8 coordinate
    localparam int EDGE_W  = 17;          // coordinate difference
    localparam int PROD_W  = 2 * EDGE_W;  // edge product
    localparam int CRS_W   = PROD_W + 1;  // cross product component
    localparam int MAG_W   = PROD_W;      // cross product magnitude
    localparam int POS_W   = 6;           // leading one position of a magnitude
    localparam int NRM_W   = 31;          // normalised magnitude, top bit at 30
    localparam int NRM_TOP = NRM_W - 1;
    localparam int SQR_W   = 2 * NRM_W;   // square of a normalised magnitude
    localparam int SUM_W   = 64;          // sum of squares
    localparam int SQRT_N  = SUM_W / 2;   // root bits, one per stage
    localparam int LEN_W   = SQRT_N;      // vector length
    localparam int QB      = 14;          // fraction bits of the result
    localparam int Q_W     = QB + 1;      // quotient bits
    localparam int REM_W   = NRM_W + QB + 1;
    localparam int OUT_W   = 16;

    localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(1) << QB;

    typedef struct packed {
        logic signed [CRD_W-1:0] a_x;
        logic signed [CRD_W-1:0] a_y;
        logic signed [CRD_W-1:0] b_x;
        logic signed [CRD_W-1:0] b_y;
        logic signed [CRD_W-1:0] c_x;
        logic signed [CRD_W-1:0] c_y;
        logic signed [CRD_W-1:0] low_height;
        logic signed [CRD_W-1:0] high_height;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] norm_x;
        logic signed [OUT_W-1:0] norm_y;
        logic signed [OUT_W-1:0] norm_z;
        logic                    degenerate;
    } t_out;

    // per component sign information, carried down the pipe
    typedef struct packed {
        logic [2:0] pos;
        logic [2:0] zero;
        logic       degen;
    } t_flags;

    typedef struct packed {
        t_flags                 f;
        logic [2:0][NRM_W-1:0] m;
    } t_side;

endpackage

// ===== rtl/core/triangle_unit_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Negated unit normal of a triangle given as three 2-D points and two heights.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready / i_in_data carry one triangle a beat.
// Output channel: o_out_valid / i_out_ready / o_out_data carry the normal in
// signed Q2.14 plus a degenerate flag set when the cross product is zero.
// The pipeline holds 56 register stages: edges, products, cross product,
// leading one search, block shift, squares, sum, 32 square root stages (one
// root bit each), numerator set-up, 15 restoring divide stages (one quotient
// bit each, three lanes) and the output register. One beat is taken and one
// result given every cycle while the receiver does not stall the output.
// All stages advance together while the output register is empty or being
// taken; when the receiver stalls with a result waiting, the whole pipe holds
// and o_in_ready drops, nothing is lost or repeated.
// Reset clears every stage valid bit; the data registers are not reset.
// ----------------------------------------------------------------------------
module triangle_unit_normal (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tun_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tun_pkg::t_out  o_out_data
);

    localparam int SQ_N = tun_pkg::SQRT_N;
    localparam int DV_N = tun_pkg::Q_W;

    logic en;

    // stage valids
    logic              r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_vn, r_vo;
    logic [SQ_N-1:0]   r_sq_v;
    logic [DV_N-1:0]   r_dv_v;

    // stage 1: edges
    logic signed [tun_pkg::EDGE_W-1:0] r_ux, r_uy, r_vx, r_vy, r_vz;
    // stage 2: products
    logic signed [tun_pkg::PROD_W-1:0] r_p_uyvz, r_p_uxvz, r_p_uxvy, r_p_uyvx;
    // stage 3: magnitudes
    logic [2:0][tun_pkg::MAG_W-1:0]    r3_m;
    tun_pkg::t_flags                   r3_f;
    // stage 4: leading one
    logic [2:0][tun_pkg::MAG_W-1:0]    r4_m;
    logic [tun_pkg::POS_W-1:0]         r4_pos;
    tun_pkg::t_flags                   r4_f;
    // stage 5..7
    tun_pkg::t_side                    r5_side, r6_side, r7_side;
    logic [2:0][tun_pkg::SQR_W-1:0]    r6_sq;
    logic [tun_pkg::SUM_W-1:0]         r7_sum;
    // square root stages
    logic [tun_pkg::SUM_W-1:0]         r_sq_s    [0:SQ_N-1];
    logic [tun_pkg::SUM_W-1:0]         r_sq_r    [0:SQ_N-1];
    tun_pkg::t_side                    r_sq_side [0:SQ_N-1];
    logic [tun_pkg::SUM_W-1:0]         n_sq_s    [0:SQ_N-1];
    logic [tun_pkg::SUM_W-1:0]         n_sq_r    [0:SQ_N-1];
    // divide set-up and stages
    logic [2:0][tun_pkg::REM_W-1:0]    r_nd_rem;
    logic [tun_pkg::LEN_W-1:0]         r_nd_len;
    tun_pkg::t_flags                   r_nd_f;
    logic [2:0][tun_pkg::REM_W-1:0]    r_dv_rem  [0:DV_N-1];
    logic [2:0][tun_pkg::Q_W-1:0]      r_dv_q    [0:DV_N-1];
    logic [tun_pkg::LEN_W-1:0]         r_dv_len  [0:DV_N-1];
    tun_pkg::t_flags                   r_dv_f    [0:DV_N-1];
    logic [2:0][tun_pkg::REM_W-1:0]    n_dv_rem  [0:DV_N-1];
    logic [2:0][tun_pkg::Q_W-1:0]      n_dv_q    [0:DV_N-1];
    // output
    tun_pkg::t_out                     r_out;

    // combinational stage logic
    logic signed [tun_pkg::CRS_W-1:0]  n_crs [0:2];
    logic [tun_pkg::MAG_W-1:0]         n_or;
    logic [tun_pkg::POS_W-1:0]         n_pos;
    tun_pkg::t_side                    n5_side;
    logic [tun_pkg::LEN_W-1:0]         sq_len;
    logic [2:0][tun_pkg::OUT_W-1:0]    n_norm;

    assign en          = !r_vo || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vo;
    assign o_out_data  = r_out;

    always_comb begin
        n_crs[0] = tun_pkg::CRS_W'(r_p_uyvz);
        n_crs[1] = -tun_pkg::CRS_W'(r_p_uxvz);
        n_crs[2] = tun_pkg::CRS_W'(r_p_uxvy) - tun_pkg::CRS_W'(r_p_uyvx);
    end

    // leading one of the OR equals that of the largest magnitude
    always_comb begin
        n_or  = r3_m[0] | r3_m[1] | r3_m[2];
        n_pos = '0;
        for (int b = 0; b < tun_pkg::MAG_W; b++) begin
            if (n_or[b]) begin
                n_pos = tun_pkg::POS_W'(b);
            end
        end
    end

    always_comb begin
        n5_side.f = r4_f;
        for (int c = 0; c < 3; c++) begin
            if (r4_pos >= tun_pkg::POS_W'(tun_pkg::NRM_TOP)) begin
                n5_side.m[c] = tun_pkg::NRM_W'(r4_m[c] >> (r4_pos - tun_pkg::POS_W'(tun_pkg::NRM_TOP)));
            end else begin
                n5_side.m[c] = tun_pkg::NRM_W'(r4_m[c] << (tun_pkg::POS_W'(tun_pkg::NRM_TOP) - r4_pos));
            end
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam logic [tun_pkg::SUM_W-1:0] BIT = tun_pkg::SUM_W'(1) << (tun_pkg::SUM_W - 2 - 2 * k);
        logic [tun_pkg::SUM_W-1:0] src_s, src_r, trial;
        if (k == 0) begin : g_first
            assign src_s = r7_sum;
            assign src_r = '0;
        end else begin : g_next
            assign src_s = r_sq_s[k-1];
            assign src_r = r_sq_r[k-1];
        end
        assign trial = src_r + BIT;
        always_comb begin
            if (src_s >= trial) begin
                n_sq_s[k] = src_s - trial;
                n_sq_r[k] = (src_r >> 1) + BIT;
            end else begin
                n_sq_s[k] = src_s;
                n_sq_r[k] = src_r >> 1;
            end
        end
    end

    assign sq_len = tun_pkg::LEN_W'(r_sq_r[SQ_N-1]);

    // restoring divide, one quotient bit per stage in three lanes
    for (genvar j = 0; j < DV_N; j++) begin : g_div
        localparam int SH = DV_N - 1 - j;
        logic [2:0][tun_pkg::REM_W-1:0] src_rem;
        logic [2:0][tun_pkg::Q_W-1:0]   src_q;
        logic [tun_pkg::LEN_W-1:0]      src_len;
        logic [tun_pkg::REM_W-1:0]      dsr;
        if (j == 0) begin : g_first
            assign src_rem = r_nd_rem;
            assign src_q   = '0;
            assign src_len = r_nd_len;
        end else begin : g_next
            assign src_rem = r_dv_rem[j-1];
            assign src_q   = r_dv_q[j-1];
            assign src_len = r_dv_len[j-1];
        end
        assign dsr = tun_pkg::REM_W'(src_len) << SH;
        always_comb begin
            for (int c = 0; c < 3; c++) begin
                if (src_rem[c] >= dsr) begin
                    n_dv_rem[j][c] = src_rem[c] - dsr;
                    n_dv_q[j][c]   = src_q[c] | (tun_pkg::Q_W'(1) << SH);
                end else begin
                    n_dv_rem[j][c] = src_rem[c];
                    n_dv_q[j][c]   = src_q[c];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [tun_pkg::Q_W-1:0] q;
            q = r_dv_q[DV_N-1][c];
            if (q > tun_pkg::ONE_Q14) begin
                q = tun_pkg::ONE_Q14;
            end
            if (r_dv_f[DV_N-1].degen || r_dv_f[DV_N-1].zero[c]) begin
                n_norm[c] = '0;
            end else if (r_dv_f[DV_N-1].pos[c]) begin
                n_norm[c] = -tun_pkg::OUT_W'(q);
            end else begin
                n_norm[c] = tun_pkg::OUT_W'(q);
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
            r_sq_v <= '0;
            r_vn   <= 1'b0;
            r_dv_v <= '0;
            r_vo   <= 1'b0;
        end else if (en) begin
            r_v1   <= i_in_valid;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v5   <= r_v4;
            r_v6   <= r_v5;
            r_v7   <= r_v6;
            r_sq_v <= {r_sq_v[SQ_N-2:0], r_v7};
            r_vn   <= r_sq_v[SQ_N-1];
            r_dv_v <= {r_dv_v[DV_N-2:0], r_vn};
            r_vo   <= r_dv_v[DV_N-1];
        end
    end

    // data path
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ux <= tun_pkg::EDGE_W'(i_in_data.b_x) - tun_pkg::EDGE_W'(i_in_data.a_x);
            r_uy <= tun_pkg::EDGE_W'(i_in_data.b_y) - tun_pkg::EDGE_W'(i_in_data.a_y);
            r_vx <= tun_pkg::EDGE_W'(i_in_data.c_x) - tun_pkg::EDGE_W'(i_in_data.a_x);
            r_vy <= tun_pkg::EDGE_W'(i_in_data.c_y) - tun_pkg::EDGE_W'(i_in_data.a_y);
            r_vz <= tun_pkg::EDGE_W'(i_in_data.high_height)
                  - tun_pkg::EDGE_W'(i_in_data.low_height);

            r_p_uyvz <= r_uy * r_vz;
            r_p_uxvz <= r_ux * r_vz;
            r_p_uxvy <= r_ux * r_vy;
            r_p_uyvx <= r_uy * r_vx;

            for (int c = 0; c < 3; c++) begin
                r3_m[c]      <= tun_pkg::MAG_W'(n_crs[c] < 0 ? -n_crs[c] : n_crs[c]);
                r3_f.pos[c]  <= n_crs[c] > 0;
                r3_f.zero[c] <= n_crs[c] == '0;
            end
            r3_f.degen <= (n_crs[0] == '0) && (n_crs[1] == '0) && (n_crs[2] == '0);

            r4_m   <= r3_m;
            r4_pos <= n_pos;
            r4_f   <= r3_f;

            r5_side <= n5_side;

            r6_side <= r5_side;
            for (int c = 0; c < 3; c++) begin
                r6_sq[c] <= r5_side.m[c] * r5_side.m[c];
            end

            r7_side <= r6_side;
            r7_sum  <= tun_pkg::SUM_W'(r6_sq[0]) + tun_pkg::SUM_W'(r6_sq[1])
                     + tun_pkg::SUM_W'(r6_sq[2]);

            for (int k = 0; k < SQ_N; k++) begin
                r_sq_s[k]    <= n_sq_s[k];
                r_sq_r[k]    <= n_sq_r[k];
                r_sq_side[k] <= (k == 0) ? r7_side : r_sq_side[(k == 0) ? 0 : k - 1];
            end

            // numerator with half the divisor added for rounding
            for (int c = 0; c < 3; c++) begin
                r_nd_rem[c] <= {1'b0, r_sq_side[SQ_N-1].m[c], tun_pkg::QB'(0)}
                             + tun_pkg::REM_W'(sq_len >> 1);
            end
            r_nd_len <= sq_len;
            r_nd_f   <= r_sq_side[SQ_N-1].f;

            for (int j = 0; j < DV_N; j++) begin
                r_dv_rem[j] <= n_dv_rem[j];
                r_dv_q[j]   <= n_dv_q[j];
                r_dv_len[j] <= (j == 0) ? r_nd_len : r_dv_len[(j == 0) ? 0 : j - 1];
                r_dv_f[j]   <= (j == 0) ? r_nd_f : r_dv_f[(j == 0) ? 0 : j - 1];
            end

            r_out.norm_x     <= n_norm[0];
            r_out.norm_y     <= n_norm[1];
            r_out.norm_z     <= n_norm[2];
            r_out.degenerate <= r_dv_f[DV_N-1].degen;
        end
    end

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.norm_x == '0 && o_out_data.norm_y == '0 && o_out_data.norm_z == '0)
        else $error("degenerate beat with non-zero normal");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.norm_x <= 16'sd16384 && o_out_data.norm_x >= -16'sd16384) &&
            (o_out_data.norm_y <= 16'sd16384 && o_out_data.norm_y >= -16'sd16384) &&
            (o_out_data.norm_z <= 16'sd16384 && o_out_data.norm_z >= -16'sd16384))
        else $error("normal component outside unit range");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && r_dv_v == '0)
        else $error("pipe valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(r_sq_v) && $stable(r_dv_v))
        else $error("pipe moved while output stalled");
`endif

endmodule
